@@ rtl/ppmc_pkg.sv @@
// ---------------------------------------------------------------------------
// ppmc_pkg
// Shared types, codes and defaults of the page poison map checker.
// ---------------------------------------------------------------------------
package ppmc_pkg;

    localparam int DEF_MAP_PAGES  = 32768;
    localparam int DEF_PAGE_SHIFT = 12;

    // APB register file: five registers, 64 bits, 8-byte stride
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;
    localparam int REG_IW = 3;

    localparam logic [REG_IW-1:0] REG_CHECK_ENABLE   = 3'd0;
    localparam logic [REG_IW-1:0] REG_MAP_PAGES      = 3'd1;
    localparam logic [REG_IW-1:0] REG_IO_LIMIT_PAGES = 3'd2;
    localparam logic [REG_IW-1:0] REG_DMAP_BASE      = 3'd3;
    localparam logic [REG_IW-1:0] REG_KIMG_BASE      = 3'd4;

    localparam logic        RST_CHECK_ENABLE   = 1'b0;
    localparam logic [15:0] RST_MAP_PAGES      = 16'd32768;
    localparam logic [20:0] RST_IO_LIMIT_PAGES = 21'd786432;
    localparam logic [63:0] RST_DMAP_BASE      = 64'hFFFF_8000_0000_0000;
    localparam logic [63:0] RST_KIMG_BASE      = 64'hFFFF_FFFF_8000_0000;

    localparam logic REQ_CHECK = 1'b0;
    localparam logic REQ_MARK  = 1'b1;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_POISON = 2'd1;
    localparam logic [1:0] KIND_NOMAP  = 2'd2;

    typedef struct packed {
        logic        check_enable;
        logic [15:0] map_pages;
        logic [20:0] io_limit_pages;
        logic [63:0] dmap_base;
        logic [63:0] kimg_base;
    } t_cfg;

    typedef struct packed {
        logic        req_type;
        logic [63:0] addr;
        logic [31:0] size;
        logic        is_write;
        logic        poison;
    } t_req;

    typedef struct packed {
        logic        fault;
        logic [1:0]  fault_kind;
        logic        fault_write;
        logic [63:0] fault_addr;
    } t_rsp;

    // map port control from the sequencer
    typedef struct packed {
        logic rd;
        logic wr;
        logic wdata;
    } t_map_ctl;

endpackage

@@ rtl/ppmc_regs.sv @@
// ---------------------------------------------------------------------------
// ppmc_regs
// APB register file holding the checker configuration.
// ---------------------------------------------------------------------------
module ppmc_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ppmc_pkg::APB_AW-1:0] paddr,
    input  logic [ppmc_pkg::APB_DW-1:0] pwdata,
    output logic [ppmc_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output ppmc_pkg::t_cfg              o_cfg
);
    import ppmc_pkg::*;

    t_cfg              r_cfg;
    logic [REG_IW-1:0] w_idx;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[APB_AW-1:APB_AW-REG_IW];
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_enable   <= RST_CHECK_ENABLE;
            r_cfg.map_pages      <= RST_MAP_PAGES;
            r_cfg.io_limit_pages <= RST_IO_LIMIT_PAGES;
            r_cfg.dmap_base      <= RST_DMAP_BASE;
            r_cfg.kimg_base      <= RST_KIMG_BASE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_CHECK_ENABLE:   r_cfg.check_enable   <= pwdata[0];
                REG_MAP_PAGES:      r_cfg.map_pages      <= pwdata[15:0];
                REG_IO_LIMIT_PAGES: r_cfg.io_limit_pages <= pwdata[20:0];
                REG_DMAP_BASE:      r_cfg.dmap_base      <= pwdata;
                REG_KIMG_BASE:      r_cfg.kimg_base      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_CHECK_ENABLE:   prdata = APB_DW'(r_cfg.check_enable);
            REG_MAP_PAGES:      prdata = APB_DW'(r_cfg.map_pages);
            REG_IO_LIMIT_PAGES: prdata = APB_DW'(r_cfg.io_limit_pages);
            REG_DMAP_BASE:      prdata = r_cfg.dmap_base;
            REG_KIMG_BASE:      prdata = r_cfg.kimg_base;
            default:            prdata = '0;
        endcase
    end

endmodule

@@ rtl/ppmc_map.sv @@
// ---------------------------------------------------------------------------
// ppmc_map
// One-bit-per-page poison memory with a clearing pass after reset.
// ---------------------------------------------------------------------------
module ppmc_map #(
    parameter int MAP_PAGES = ppmc_pkg::DEF_MAP_PAGES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ppmc_pkg::t_map_ctl           i_ctl,
    input  logic [$clog2(MAP_PAGES)-1:0] i_addr,
    output logic                         o_rdata,
    output logic                         o_busy
);
    import ppmc_pkg::*;

    localparam int IDX_W = $clog2(MAP_PAGES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAP_PAGES - 1);

    logic             mem [MAP_PAGES];
    logic             r_busy;
    logic [IDX_W-1:0] r_clr_idx;
    logic             r_rdata;

    assign o_busy  = r_busy;
    assign o_rdata = r_rdata;

    // clear sweep, one page per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            if (r_clr_idx == LAST_IDX) begin
                r_busy <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr_idx] <= 1'b0;
        end else if (i_ctl.wr) begin
            mem[i_addr] <= i_ctl.wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= mem[i_addr];
        end
    end

endmodule

@@ rtl/ppmc_walk.sv @@
// ---------------------------------------------------------------------------
// ppmc_walk
// Request sequencer: page range setup, map walk, fault evaluation and the
// result register.
// ---------------------------------------------------------------------------
module ppmc_walk #(
    parameter int MAP_PAGES  = ppmc_pkg::DEF_MAP_PAGES,
    parameter int PAGE_SHIFT = ppmc_pkg::DEF_PAGE_SHIFT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ppmc_pkg::t_cfg               i_cfg,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  ppmc_pkg::t_req               i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output ppmc_pkg::t_rsp               o_out_data,
    input  logic                         i_map_busy,
    output ppmc_pkg::t_map_ctl           o_map_ctl,
    output logic [$clog2(MAP_PAGES)-1:0] o_map_addr,
    input  logic                         i_map_rdata
);
    import ppmc_pkg::*;

    localparam int IDX_W = $clog2(MAP_PAGES);
    localparam int PG_W  = 64 - PAGE_SHIFT;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_IDX  = 3'd2;
    localparam logic [2:0] S_MARK = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_EVAL = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]      r_state, n_state;
    t_req            r_req;
    logic [63:0]     r_szm1;
    logic [63:0]     r_lst;
    logic            r_skip;
    logic            r_use_kt;
    logic [63:0]     r_base;
    logic [PG_W-1:0] r_lp, r_rp, r_lim, r_fl, r_pend_lp;
    logic            r_pend;
    logic [63:0]     r_pa;
    logic            r_fault;
    logic [1:0]      r_kind;
    logic            r_out_valid;
    t_rsp            r_out;

    logic            w_accept;
    logic            w_out_free;
    logic [63:0]     w_base;
    logic [63:0]     w_lo_off, w_hi_off;
    logic [PG_W-1:0] w_mp;
    logic            w_inr;
    logic            w_hit;

    assign o_in_stall  = (r_state != S_IDLE) || i_map_busy;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        if (r_req.req_type == REQ_MARK) begin
            w_base = '0;
        end else if (r_use_kt) begin
            w_base = i_cfg.kimg_base;
        end else begin
            w_base = i_cfg.dmap_base;
        end
    end

    assign w_lo_off = r_req.addr - w_base;
    assign w_hi_off = r_lst - w_base;
    assign w_mp     = PG_W'(i_cfg.map_pages);

    assign w_inr = (r_lp <= r_rp) && (r_lp < r_lim);
    assign w_hit = r_pend && i_map_rdata;

    assign o_map_addr      = r_lp[IDX_W-1:0];
    assign o_map_ctl.rd    = (r_state == S_WALK) && !w_hit && w_inr;
    assign o_map_ctl.wr    = (r_state == S_MARK) && w_inr;
    assign o_map_ctl.wdata = r_req.poison;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_PREP;
            S_PREP: n_state = S_IDX;
            S_IDX: begin
                if (r_skip) begin
                    n_state = S_OUT;
                end else if (r_req.req_type == REQ_MARK) begin
                    n_state = S_MARK;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_MARK: if (!w_inr) n_state = S_OUT;
            S_WALK: if (w_hit || !w_inr) n_state = S_EVAL;
            S_EVAL: n_state = S_OUT;
            S_OUT:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_IDX) begin
                r_pend <= 1'b0;
            end else if (r_state == S_WALK) begin
                r_pend <= o_map_ctl.rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_req  <= i_in_data;
                    r_szm1 <= 64'(i_in_data.size) - 64'd1;
                end
            end
            S_PREP: begin
                r_lst    <= r_req.addr + r_szm1;
                r_use_kt <= r_req.addr >= i_cfg.kimg_base;
                r_skip   <= (r_req.size == '0) ||
                            (r_req.req_type == REQ_CHECK &&
                             (!i_cfg.check_enable || r_req.addr < i_cfg.dmap_base));
            end
            S_IDX: begin
                r_base  <= w_base;
                r_lp    <= w_lo_off[63:PAGE_SHIFT];
                r_rp    <= w_hi_off[63:PAGE_SHIFT];
                r_lim   <= (w_mp < PG_W'(MAP_PAGES)) ? w_mp : PG_W'(MAP_PAGES);
                r_fault <= 1'b0;
            end
            S_MARK: begin
                if (w_inr) begin
                    r_lp <= r_lp + 1'b1;
                end
            end
            S_WALK: begin
                // a poisoned page returned by the previous read ends the walk
                if (w_hit) begin
                    r_fl <= r_pend_lp;
                end else begin
                    r_fl <= r_lp;
                    if (w_inr) begin
                        r_pend_lp <= r_lp;
                        r_lp      <= r_lp + 1'b1;
                    end
                end
            end
            S_EVAL: begin
                r_pa    <= r_base + {r_fl, PAGE_SHIFT'(0)};
                r_fault <= (r_fl <= r_rp) && (r_fl < PG_W'(i_cfg.io_limit_pages));
                r_kind  <= (r_fl < r_lim) ? KIND_POISON : KIND_NOMAP;
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_out.fault       <= r_fault;
                    r_out.fault_kind  <= r_fault ? r_kind : KIND_NONE;
                    r_out.fault_write <= r_fault && r_req.is_write;
                    if (!r_fault) begin
                        r_out.fault_addr <= '0;
                    end else if (r_req.addr > r_pa) begin
                        r_out.fault_addr <= r_req.addr;
                    end else begin
                        r_out.fault_addr <= r_pa;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/page_poison_map_checker_top.sv @@
// Sequence: a check steps through prepare, index, walk, evaluate and output;
// a mark through prepare, index, mark and output. At most the map size in
// pages is walked. Throughput: one transaction at a time; the single map
// port reads or writes one page per cycle.
// Reset: configuration returns to its defaults and the map is cleared by a
// sweep over all MAP_PAGES pages, during which input stays stalled.
// ---------------------------------------------------------------------------
// page_poison_map_checker_top
// Page poison map checker: marks page ranges and checks accesses against a
// one-bit-per-page poison map.
// ---------------------------------------------------------------------------
module page_poison_map_checker_top #(
    parameter int MAP_PAGES  = ppmc_pkg::DEF_MAP_PAGES,
    parameter int PAGE_SHIFT = ppmc_pkg::DEF_PAGE_SHIFT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ppmc_pkg::t_req              i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ppmc_pkg::t_rsp              o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ppmc_pkg::APB_AW-1:0] paddr,
    input  logic [ppmc_pkg::APB_DW-1:0] pwdata,
    output logic [ppmc_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import ppmc_pkg::*;

    localparam int IDX_W = $clog2(MAP_PAGES);

    t_cfg             w_cfg;
    t_map_ctl         w_map_ctl;
    logic [IDX_W-1:0] w_map_addr;
    logic             w_map_rdata;
    logic             w_map_busy;

    ppmc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ppmc_map #(
        .MAP_PAGES (MAP_PAGES)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_map_ctl),
        .i_addr  (w_map_addr),
        .o_rdata (w_map_rdata),
        .o_busy  (w_map_busy)
    );

    ppmc_walk #(
        .MAP_PAGES  (MAP_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_map_busy  (w_map_busy),
        .o_map_ctl   (w_map_ctl),
        .o_map_addr  (w_map_addr),
        .i_map_rdata (w_map_rdata)
    );

endmodule
